>>> hw/rtl/mtte_pkg.sv
package mtte_pkg;

  localparam int unsigned KeyW       = 4;
  localparam int unsigned TapW       = 2;
  localparam int unsigned TickW      = 16;
  localparam int unsigned FieldW     = 3;
  localparam int unsigned CharW      = 7;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 16;

  localparam int unsigned MaxLineDefault = 32;

  localparam logic [TickW-1:0]  TimeoutReset    = 16'd1000;
  localparam logic [FieldW-1:0] FieldCountReset = 3'd3;
  localparam logic [TickW-1:0]  TickMax         = 16'hFFFF;

  // key codes
  localparam logic [KeyW-1:0] KeyStar = 4'd10;
  localparam logic [KeyW-1:0] KeyHash = 4'd11;
  localparam logic [KeyW-1:0] KeyNone = 4'd15;
  localparam logic [KeyW-1:0] KeyMaxDigit = 4'd9;

  localparam logic [CharW-1:0] CharZero = 7'h30;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFieldCount = 1'b1;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActAppend = 2'd1,
    ActDelete = 2'd2
  } action_e;

  // characters on each digit key
  function automatic logic [2:0] group_len(input logic [KeyW-1:0] k);
    logic [2:0] n;
    case (k)
      4'd7, 4'd9:                   n = 3'd4;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
      4'd8:                         n = 3'd3;
      default:                      n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [CharW-1:0] group_char(input logic [KeyW-1:0] k,
                                                  input logic [TapW-1:0] t);
    logic [CharW-1:0] c;
    case (k)
      4'd0:    c = 7'h30;
      4'd1:    c = 7'h31;
      4'd2:    c = 7'h41 + {5'd0, t};
      4'd3:    c = 7'h44 + {5'd0, t};
      4'd4:    c = 7'h47 + {5'd0, t};
      4'd5:    c = 7'h4A + {5'd0, t};
      4'd6:    c = 7'h4D + {5'd0, t};
      4'd7:    c = 7'h50 + {5'd0, t};
      4'd8:    c = 7'h54 + {5'd0, t};
      4'd9:    c = 7'h57 + {5'd0, t};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/multi_tap_text_entry.sv
// Multi-tap keypad text entry. Each input word is either a key press
// (s_axis_tuser = 0, key 0-9 digit, 10 star, 11 hash) or one timer tick
// (s_axis_tuser = 1), and each gives exactly one result word: an append
// of an ASCII character, a delete of the last character, or nothing, plus
// the field status. Repeated presses of a digit within timeout_ticks step
// through its letters; another digit, the timeout or hash commits the
// pending letter; star drops it and deletes; hash closes the field
// (m_axis_tlast). The last field takes digits directly. Throughput is one
// word per clock unless m_axis_tready holds a result back; words pass the
// input register, then the result register, updating state between them.
// A word is accepted while a result waits if the result register frees in
// that cycle. Writing field_count restarts the entry; configuration is to
// be written only while the block is idle; the block does not enforce it.
module multi_tap_text_entry #(
  parameter int unsigned MAX_LINE = mtte_pkg::MaxLineDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [mtte_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mtte_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mtte_pkg::InDataW-1:0]      s_axis_tdata,  // [3:0] key
  input  logic                              s_axis_tuser,  // [0] func
  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mtte_pkg::OutDataW-1:0]     m_axis_tdata,  // [6:0] char_code,
                                                           // [9:7] fields_left,
                                                           // [10] all_done
  output logic [1:0]                        m_axis_tuser,  // [1:0] action
  output logic                              m_axis_tlast   // field_done
);
  import mtte_pkg::*;

  localparam int unsigned LineW = $clog2(MAX_LINE + 1);
  localparam logic [LineW-1:0] LineMax = LineW'(MAX_LINE);

  // configuration; field_count only matters at the restart it causes
  logic [TickW-1:0]  timeout_q;

  // input register
  logic              in_valid_q;
  logic              in_func_q;
  logic [KeyW-1:0]   in_key_q;

  // entry state
  logic [KeyW-1:0]   pend_q, pend_d;
  logic [TapW-1:0]   tap_q, tap_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic [FieldW-1:0] fields_q, fields_d;
  logic [LineW-1:0]  line_q, line_d;

  // result register
  logic              out_valid_q;
  action_e           act_q, act_d;
  logic [CharW-1:0]  chr_q, chr_d;
  logic              done_q, done_d;
  logic [FieldW-1:0] left_q;
  logic              all_q;

  logic advance;
  logic restart;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign restart       = cfg_we_i && (cfg_idx_i == CfgFieldCount);

  // helpers for committing the pending letter
  logic [TapW-1:0]  tap_fix;
  logic [CharW-1:0] commit_chr;
  logic             line_room;
  logic [TickW-1:0] elapsed_inc;
  logic [2:0]       tap_nx;
  logic [2:0]       key_len;

  always_comb begin
    tap_fix     = ({1'b0, tap_q} >= group_len(pend_q)) ? '0 : tap_q;
    commit_chr  = group_char(pend_q, tap_fix);
    line_room   = line_q < LineMax;
    elapsed_inc = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + 1'b1;
    key_len     = group_len(in_key_q);
    tap_nx      = {1'b0, tap_q} + 3'd1;
  end

  always_comb begin
    pend_d    = pend_q;
    tap_d     = tap_q;
    elapsed_d = elapsed_q;
    fields_d  = fields_q;
    line_d    = line_q;
    act_d     = ActNone;
    chr_d     = '0;
    done_d    = 1'b0;

    if (fields_q != '0) begin
      if (in_func_q) begin
        // timer tick
        elapsed_d = elapsed_inc;
        if (pend_q != KeyNone && elapsed_inc >= timeout_q) begin
          if (line_room) begin
            act_d  = ActAppend;
            chr_d  = commit_chr;
            line_d = line_q + 1'b1;
          end
          pend_d = KeyNone;
          tap_d  = '0;
        end
      end else if (in_key_q <= KeyMaxDigit) begin
        if (fields_q == FieldW'(1)) begin
          // digits-only field
          if (line_room) begin
            act_d  = ActAppend;
            chr_d  = CharZero + {3'd0, in_key_q};
            line_d = line_q + 1'b1;
          end
        end else if (pend_q == in_key_q && elapsed_q < timeout_q) begin
          tap_d     = (tap_nx >= key_len) ? '0 : tap_nx[TapW-1:0];
          elapsed_d = '0;
        end else begin
          if (pend_q != KeyNone && line_room) begin
            act_d  = ActAppend;
            chr_d  = commit_chr;
            line_d = line_q + 1'b1;
          end
          pend_d    = in_key_q;
          tap_d     = '0;
          elapsed_d = '0;
        end
      end else if (in_key_q == KeyStar) begin
        pend_d = KeyNone;
        tap_d  = '0;
        if (line_q != '0) begin
          line_d = line_q - 1'b1;
          act_d  = ActDelete;
        end
      end else if (in_key_q == KeyHash) begin
        // commit, then close the field
        if (pend_q != KeyNone && line_room) begin
          act_d = ActAppend;
          chr_d = commit_chr;
        end
        pend_d   = KeyNone;
        tap_d    = '0;
        line_d   = '0;
        fields_d = fields_q - 1'b1;
        done_d   = 1'b1;
      end
    end
  end

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i && (cfg_idx_i == CfgTimeout)) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // entry state; a field_count write restarts it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= KeyNone;
      tap_q     <= '0;
      elapsed_q <= '0;
      fields_q  <= FieldCountReset;
      line_q    <= '0;
    end else if (restart) begin
      pend_q    <= KeyNone;
      tap_q     <= '0;
      elapsed_q <= '0;
      fields_q  <= cfg_wdata_i[FieldW-1:0];
      line_q    <= '0;
    end else if (advance) begin
      pend_q    <= pend_d;
      tap_q     <= tap_d;
      elapsed_q <= elapsed_d;
      fields_q  <= fields_d;
      line_q    <= line_d;
    end
  end

  // handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= s_axis_tuser;
      in_key_q  <= s_axis_tdata[KeyW-1:0];
    end
    if (advance) begin
      act_q  <= act_d;
      chr_q  <= chr_d;
      done_q <= done_d;
      left_q <= fields_d;
      all_q  <= (fields_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = act_q;
  assign m_axis_tlast  = done_q;
  assign m_axis_tdata  = {{(OutDataW - CharW - FieldW - 1){1'b0}}, all_q, left_q, chr_q};

endmodule
